@@ rtl/csq_pkg.sv @@
// Shared types and codes for the counting semaphore with a FIFO wait queue.
// Depends on nothing; the top level imports it, csq_ram does not.
`default_nettype none

package csq_pkg;

   typedef enum logic [1:0] {
      CMD_WAIT   = 2'd0,
      CMD_SIGNAL = 2'd1,
      CMD_CLOSE  = 2'd2,
      CMD_INIT   = 2'd3
   } csq_cmd_type;

   typedef enum logic [2:0] {
      ACT_PROCEED   = 3'd0,
      ACT_BLOCK     = 3'd1,
      ACT_WOKEN     = 3'd2,
      ACT_WOKEN_ERR = 3'd3,
      ACT_OVERFLOW  = 3'd4,
      ACT_NOTHING   = 3'd5
   } csq_act_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RESP
   } csq_state_type;

   localparam logic signed [15:0] COUNT_MAX = 16'sh7FFF;
   localparam logic signed [15:0] COUNT_MIN = 16'sh8000;

   typedef struct packed {
      logic [1:0]  command;
      logic [7:0]  thread_id;
      logic [14:0] init_value;
   } csq_req_type;

   typedef struct packed {
      logic [2:0]         action;
      logic [7:0]         woken_id;
      logic signed [15:0] count_now;
      logic               last;
   } csq_rsp_type;

endpackage

`default_nettype wire

@@ rtl/counting_semaphore_wait_queue.sv @@
// Counting semaphore with a FIFO wait queue; top level. Uses csq_pkg and csq_ram.
// Each command word is accepted in idle, executed, and its result word registered and
// then delivered; wait, signal and init give one result word each. A close with N>0
// waiters gives N words, one execute and one deliver step per waiter, paced by the
// single queue read port. A new command is taken only after the last word has gone out.
// Reset is synchronous: count, pointers and occupancy clear at once; no clearing pass.
`default_nettype none

module counting_semaphore_wait_queue
   import csq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16,
   parameter int ID_WIDTH    = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire csq_req_type req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output csq_rsp_type      rsp_data
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
   localparam int XW    = (ID_WIDTH > 8) ? ID_WIDTH : 8;
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [OCC_W-1:0] FULL_OCC  = OCC_W'(QUEUE_DEPTH);

   // Sequencer state.
   csq_state_type state_ff, state_in;

   // Captured command word.
   logic [1:0]          cmd_ff;
   logic [ID_WIDTH-1:0] tid_ff;
   logic [14:0]         init_ff;

   // Semaphore state.
   logic signed [15:0] count_ff, count_in;
   logic [PTR_W-1:0]   head_ff, head_in;
   logic [PTR_W-1:0]   tail_ff, tail_in;
   logic [OCC_W-1:0]   occ_ff, occ_in;

   // Result register; it holds the word while the consumer stalls.
   csq_rsp_type rsp_ff, rsp_in;

   // Sequencer outputs.
   logic accept_en;
   logic exec_en;

   // Queue memory port.
   logic                ram_we;
   logic [ID_WIDTH-1:0] ram_rd_data;

   // Shared count adder: every count step of wait and signal goes through it.
   logic signed [15:0] count_step;
   logic signed [15:0] count_sum;

   logic [XW-1:0]       tid_ext;
   logic [ID_WIDTH-1:0] tid_store;
   logic [XW-1:0]       woken_ext;
   logic [7:0]          woken_id;
   logic [PTR_W-1:0]    head_next;
   logic [PTR_W-1:0]    tail_next;

   // The caller identifier is cut to ID_WIDTH bits on the way in, and the
   // stored identifier is cut to the 8-bit field on the way out.
   assign tid_ext   = XW'(req_data.thread_id);
   assign tid_store = tid_ext[ID_WIDTH-1:0];
   assign woken_ext = XW'(ram_rd_data);
   assign woken_id  = woken_ext[7:0];

   assign head_next = (head_ff == LAST_SLOT) ? '0 : head_ff + 1'b1;
   assign tail_next = (tail_ff == LAST_SLOT) ? '0 : tail_ff + 1'b1;

   assign count_step = (cmd_ff == CMD_WAIT) ? -16'sd1 : 16'sd1;
   assign count_sum  = count_ff + count_step;

   // The read port always looks at the oldest waiter. The head moves at most
   // once per execute cycle, and a deliver cycle always lies between two
   // executes, so the registered read data is current when it is used.
   csq_ram #(
      .WIDTH (ID_WIDTH),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (tail_ff),
      .wr_data (tid_ff),
      .rd_addr (head_ff),
      .rd_data (ram_rd_data)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            // A close keeps draining until the word marked last has gone out.
            if (!rsp_stall) begin
               state_in = rsp_ff.last ? ST_IDLE : ST_EXEC;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      accept_en = 1'b0;
      exec_en   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            accept_en = req_valid;
         end
         ST_EXEC: begin
            exec_en = 1'b1;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // Command execution: one result word per execute cycle.
   always_comb begin
      count_in = count_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      occ_in   = occ_ff;
      rsp_in   = rsp_ff;
      ram_we   = 1'b0;
      if (exec_en) begin
         rsp_in.action    = ACT_PROCEED;
         rsp_in.woken_id  = '0;
         rsp_in.count_now = count_ff;
         rsp_in.last      = 1'b1;
         unique case (cmd_ff)
            CMD_WAIT: begin
               // A blocking wait needs a free slot, and the count must not wrap.
               if (count_ff == COUNT_MIN || (count_ff <= 0 && occ_ff >= FULL_OCC)) begin
                  rsp_in.action = ACT_OVERFLOW;
               end else begin
                  count_in         = count_sum;
                  rsp_in.count_now = count_sum;
                  if (count_sum < 0) begin
                     ram_we        = 1'b1;
                     tail_in       = tail_next;
                     occ_in        = occ_ff + 1'b1;
                     rsp_in.action = ACT_BLOCK;
                  end
               end
            end
            CMD_SIGNAL: begin
               if (count_ff == COUNT_MAX) begin
                  rsp_in.action = ACT_OVERFLOW;
               end else begin
                  count_in         = count_sum;
                  rsp_in.count_now = count_sum;
                  if (count_ff < 0 && occ_ff != '0) begin
                     head_in         = head_next;
                     occ_in          = occ_ff - 1'b1;
                     rsp_in.action   = ACT_WOKEN;
                     rsp_in.woken_id = woken_id;
                  end
               end
            end
            CMD_CLOSE: begin
               if (occ_ff == '0) begin
                  count_in         = '0;
                  rsp_in.action    = ACT_NOTHING;
                  rsp_in.count_now = '0;
               end else begin
                  // Drain one waiter. Earlier words carry the count from before
                  // the close; the final one carries the zeroed count.
                  occ_in          = occ_ff - 1'b1;
                  rsp_in.action   = ACT_WOKEN_ERR;
                  rsp_in.woken_id = woken_id;
                  if (occ_ff == OCC_W'(1)) begin
                     count_in         = '0;
                     head_in          = '0;
                     tail_in          = '0;
                     rsp_in.count_now = '0;
                  end else begin
                     head_in     = head_next;
                     rsp_in.last = 1'b0;
                  end
               end
            end
            CMD_INIT: begin
               // Queued waiters are dropped without any result.
               count_in         = $signed({1'b0, init_ff});
               head_in          = '0;
               tail_in          = '0;
               occ_in           = '0;
               rsp_in.count_now = $signed({1'b0, init_ff});
            end
            default: begin
               rsp_in.action = ACT_NOTHING;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         head_ff  <= '0;
         tail_ff  <= '0;
         occ_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         occ_ff   <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept_en) begin
         cmd_ff  <= req_data.command;
         tid_ff  <= tid_store;
         init_ff <= req_data.init_value;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_data = rsp_ff;

   // Between commands, a negative count means exactly that many queued waiters,
   // and a count that is not negative means an empty queue.
   logic signed [16:0] chk_balance;
   assign chk_balance = $signed(17'(occ_ff)) + 17'(count_ff);

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= FULL_OCC)
      else $error("wait queue occupancy exceeds its depth");

   a_balance: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |->
         ((count_ff < 0) ? (chk_balance == 17'sd0) : (occ_ff == '0)))
      else $error("count and queue occupancy disagree between commands");

   a_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.last) |-> (rsp_data.action == ACT_WOKEN_ERR))
      else $error("only close drain words may be followed by more words");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> ##2 rsp_valid)
      else $error("result word not presented two cycles after acceptance");

endmodule

`default_nettype wire

@@ rtl/csq_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; holds the wait queue of the semaphore.
`default_nettype none

module csq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire
